[hw/rtl/dle_character_stuffing_framer_assert.svh]
// ---------------------------------------------------------------------------
// DLE framer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef DLE_CHARACTER_STUFFING_FRAMER_ASSERT_SVH
`define DLE_CHARACTER_STUFFING_FRAMER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLECS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DLECS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/dlecs_pkg.sv]
// ---------------------------------------------------------------------------
// DLE framer package
// Character constants, output slot numbering and the command passed from the
// classifying front end to the byte sequencer.
// ---------------------------------------------------------------------------
package dlecs_pkg;

	// Characters of the flag "dlestx".
	localparam logic [7:0] CH_D = 8'h64;
	localparam logic [7:0] CH_L = 8'h6c;
	localparam logic [7:0] CH_E = 8'h65;
	localparam logic [7:0] CH_S = 8'h73;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_X = 8'h78;

	localparam int FLAG_LEN = 6;
	localparam logic [7:0] FLAG_SEQ [FLAG_LEN] = '{CH_D, CH_L, CH_E, CH_S, CH_T, CH_X};

	// Frame byte counter saturates here; destuffing starts at this count.
	localparam logic [3:0] BS_MAX = 4'd12;
	// Positions skipped after a "dledle" match.
	localparam logic [1:0] SKIP_START = 2'd3;

	// Command queue depth.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// Output slots of one command, sent lowest first.
	localparam int NSLOT  = 18;
	localparam int SLOT_W = $clog2(NSLOT);
	typedef logic [SLOT_W-1:0] slot_idx_t;
	typedef logic [NSLOT-1:0]  slot_mask_t;

	localparam slot_idx_t SLOT_HDR      = SLOT_W'(0);
	localparam slot_idx_t SLOT_INS      = SLOT_W'(6);
	localparam slot_idx_t SLOT_A        = SLOT_W'(9);
	localparam slot_idx_t SLOT_B        = SLOT_W'(10);
	localparam slot_idx_t SLOT_C        = SLOT_W'(11);
	localparam slot_idx_t SLOT_TRL      = SLOT_W'(12);
	localparam slot_idx_t SLOT_TRL_LAST = SLOT_W'(17);

	// Work caused by one input byte.
	typedef struct packed {
		logic       hdr;     // opening flag
		logic       ins;     // inserted "dle"
		logic       a_vld;
		logic       b_vld;
		logic       c_vld;
		logic       trl;     // closing flag, ends the frame
		logic       a_last;  // byte a ends the frame
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
	} cmd_t;

	// Expand a command into its slot mask.
	function automatic slot_mask_t cmd_mask(input cmd_t cmd);
		slot_mask_t m;
		m = '0;
		m[SLOT_HDR +: FLAG_LEN] = {FLAG_LEN{cmd.hdr}};
		m[SLOT_INS +: 3]        = {3{cmd.ins}};
		m[SLOT_A]               = cmd.a_vld;
		m[SLOT_B]               = cmd.b_vld;
		m[SLOT_C]               = cmd.c_vld;
		m[SLOT_TRL +: FLAG_LEN] = {FLAG_LEN{cmd.trl}};
		return m;
	endfunction

	// Fixed character of a flag or insertion slot.
	function automatic logic [7:0] slot_char(input slot_idx_t idx);
		slot_idx_t off;
		off = '0;
		if (idx < SLOT_INS) begin
			off = idx;
		end else if (idx < SLOT_A) begin
			off = idx - SLOT_INS;
		end else if (idx >= SLOT_TRL) begin
			off = idx - SLOT_TRL;
		end
		return FLAG_SEQ[off[2:0]];
	endfunction

endpackage

[hw/rtl/dlecs_front.sv]
// ---------------------------------------------------------------------------
// DLE framer front end
// Keeps the byte window and frame counters and turns each accepted byte into
// at most one command for the sequencer.
// ---------------------------------------------------------------------------
module dlecs_front
	import dlecs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic [7:0] in_char,
	input  logic       in_last,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       q_full,
	output logic       push,
	output cmd_t       cmd
);

	logic       dir_q;
	logic [7:0] win_q [7];
	logic [7:0] win_n [7];
	logic [3:0] bs_q, bs_n, bs_eff;
	logic [1:0] skip_q, skip_n;
	logic       frame_q, frame_n;
	logic       accept;
	logic       match_pair;
	logic [1:0] skip_m1;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classify the byte and compute the next frame state.
	always_comb begin
		for (int i = 0; i < 6; i++) begin
			win_n[i] = win_q[i+1];
		end
		win_n[6] = in_char;
		cmd     = '0;
		bs_n    = bs_q;
		skip_n  = skip_q;
		frame_n = frame_q;
		bs_eff  = frame_q ? bs_q : '0;
		skip_m1 = skip_q - 2'd1;
		match_pair = win_n[0] == CH_D && win_n[1] == CH_L && win_n[2] == CH_E &&
			win_n[3] == CH_D && win_n[4] == CH_L && win_n[5] == CH_E;
		if (!dir_q) begin
			// Stuffing: flag, data with a two-byte lookahead, flag.
			cmd.hdr = !frame_q;
			if (bs_eff >= 4'd2) begin
				cmd.a_vld = 1'b1;
				cmd.a     = win_n[4];
				cmd.ins   = win_n[4] == CH_D && win_n[5] == CH_L && win_n[6] == CH_E;
			end
			if (in_last) begin
				cmd.b_vld = bs_eff >= 4'd1;
				cmd.b     = win_n[5];
				cmd.c_vld = 1'b1;
				cmd.c     = win_n[6];
				cmd.trl   = 1'b1;
				bs_n      = '0;
				skip_n    = '0;
				frame_n   = 1'b0;
			end else begin
				frame_n = 1'b1;
				bs_n    = (bs_eff < BS_MAX) ? bs_eff + 4'd1 : bs_eff;
			end
		end else begin
			// Destuffing: decide the byte six positions back.
			if (bs_q >= BS_MAX) begin
				if (in_last) begin
					cmd.a_vld  = 1'b1;
					cmd.a_last = 1'b1;
					if (skip_q != '0) begin
						cmd.a = win_n[{1'b0, skip_m1}];
					end else if (match_pair) begin
						cmd.a = win_n[3];
					end else begin
						cmd.a = win_n[0];
					end
				end else if (skip_q > 2'd1) begin
					skip_n = skip_m1;
				end else if (skip_q == 2'd1) begin
					skip_n    = '0;
					cmd.a_vld = 1'b1;
					cmd.a     = win_n[0];
				end else if (match_pair) begin
					skip_n = SKIP_START;
				end else begin
					cmd.a_vld = 1'b1;
					cmd.a     = win_n[0];
				end
			end
			if (in_last) begin
				bs_n    = '0;
				skip_n  = '0;
				frame_n = 1'b0;
			end else begin
				frame_n = 1'b1;
				bs_n    = (bs_q < BS_MAX) ? bs_q + 4'd1 : bs_q;
			end
		end
	end

	assign push = accept &&
		(cmd.hdr || cmd.ins || cmd.a_vld || cmd.b_vld || cmd.c_vld || cmd.trl);

	// Frame state and window registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= 1'b0;
			bs_q    <= '0;
			skip_q  <= '0;
			frame_q <= 1'b0;
			for (int i = 0; i < 7; i++) begin
				win_q[i] <= '0;
			end
		end else if (cfg_we) begin
			dir_q   <= cfg_wdata;
			bs_q    <= '0;
			skip_q  <= '0;
			frame_q <= 1'b0;
		end else if (accept) begin
			bs_q    <= bs_n;
			skip_q  <= skip_n;
			frame_q <= frame_n;
			for (int i = 0; i < 7; i++) begin
				win_q[i] <= win_n[i];
			end
		end
	end

endmodule

[hw/rtl/dlecs_queue.sv]
// ---------------------------------------------------------------------------
// DLE framer command queue
// Small FIFO of commands between the front end and the byte sequencer.
// ---------------------------------------------------------------------------
`include "dle_character_stuffing_framer_assert.svh"

module dlecs_queue
	import dlecs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_vld,
	output cmd_t head_cmd
);

	cmd_t           entries_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full     = count_q == (QAW+1)'(QDEPTH);
	assign head_vld = count_q != '0;
	assign head_cmd = entries_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Command storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	`DLECS_ASSERT_SAME(a_no_push_full, full, !push, "command pushed into a full queue")
	`DLECS_ASSERT_SAME(a_no_pop_empty, pop, head_vld, "command popped from an empty queue")
	`DLECS_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1,
		"queue count did not follow a push")

endmodule

[hw/rtl/dlecs_back.sv]
// ---------------------------------------------------------------------------
// DLE framer byte sequencer
// Expands commands into bytes of an output register, one per unstalled cycle.
// ---------------------------------------------------------------------------
`include "dle_character_stuffing_framer_assert.svh"

module dlecs_back
	import dlecs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_vld,
	input  cmd_t       head_cmd,
	output logic       pop,
	output logic [7:0] out_char,
	output logic       out_last,
	output logic       out_valid,
	input  logic       out_ready
);

	slot_mask_t cur_mask_q, low_oh, rest;
	logic [7:0] cur_a_q, cur_b_q, cur_c_q;
	logic       cur_a_last_q;
	logic       out_vld_q, out_last_q;
	logic [7:0] out_char_q;
	logic       out_free, emit;
	slot_idx_t  idx;
	logic [7:0] next_char;
	logic       next_last;

	assign out_free = !out_vld_q || out_ready;
	assign emit     = out_free && (cur_mask_q != '0);
	assign low_oh   = cur_mask_q & (~cur_mask_q + 1'b1);
	assign rest     = cur_mask_q & ~low_oh;
	assign pop      = head_vld && ((cur_mask_q == '0) || (emit && rest == '0));

	// Pick the byte of the lowest pending slot.
	always_comb begin
		idx = '0;
		for (int i = 0; i < NSLOT; i++) begin
			if (low_oh[i]) begin
				idx = idx | SLOT_W'(i);
			end
		end
		if (idx == SLOT_A) begin
			next_char = cur_a_q;
		end else if (idx == SLOT_B) begin
			next_char = cur_b_q;
		end else if (idx == SLOT_C) begin
			next_char = cur_c_q;
		end else begin
			next_char = slot_char(idx);
		end
		next_last = low_oh[SLOT_TRL_LAST] || (low_oh[SLOT_A] && cur_a_last_q);
	end

	// Current command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mask_q <= '0;
		end else if (pop) begin
			cur_mask_q <= cmd_mask(head_cmd);
		end else if (emit) begin
			cur_mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_a_q      <= head_cmd.a;
			cur_b_q      <= head_cmd.b;
			cur_c_q      <= head_cmd.c;
			cur_a_last_q <= head_cmd.a_last;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_char_q <= next_char;
			out_last_q <= next_last;
		end
	end

	assign out_valid = out_vld_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

	`DLECS_ASSERT_NEXT(a_emit_shows, (cur_mask_q != '0) && out_free, out_vld_q,
		"pending byte not moved to the output register")
	`DLECS_ASSERT_NEXT(a_hold_stalled, (cur_mask_q != '0) && out_vld_q && !out_ready,
		cur_mask_q == $past(cur_mask_q), "command advanced while output stalled")
	`DLECS_ASSERT_SAME(a_pop_when_done, pop && (cur_mask_q != '0), emit && rest == '0,
		"new command loaded over unfinished work")

endmodule

[hw/rtl/dle_character_stuffing_framer.sv]
// ---------------------------------------------------------------------------
// DLE/STX character-stuffing framer
// Frames a byte stream with "dlestx" flags and doubled "dle", or strips them.
// ---------------------------------------------------------------------------
// The block sends one output byte per clock cycle and takes one input byte
// per cycle as long as the output keeps pace. The output sequencer sets the
// rate: in stuff mode the first byte of a frame adds the six-byte opening
// flag, each data "dle" an inserted "dle", and the last byte the held-back
// data and the closing flag. A four-entry command queue absorbs these bursts
// before the input is stalled. In destuff mode at most one byte leaves per
// input byte, so the input runs at full rate as long as the output keeps
// pace. A byte accepted on an idle block passes the command queue and the
// current-command register before it reaches the output register. Write
// direction (cfg_wdata) only while idle; a write closes any open frame.
module dle_character_stuffing_framer
	import dlecs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,       // direction: 0 stuff, 1 destuff
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,    // [7:0] in_char
	input  logic       s_axis_tlast,    // in_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,    // [7:0] out_char
	output logic       m_axis_tlast     // out_last
);

	logic q_full, push, pop, head_vld;
	cmd_t push_cmd, head_cmd;

	// Front end: window, counters and classification.
	dlecs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_char   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.q_full    (q_full),
		.push      (push),
		.cmd       (push_cmd)
	);

	// Command queue.
	dlecs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head_vld (head_vld),
		.head_cmd (head_cmd)
	);

	// Byte sequencer and output register.
	dlecs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_vld  (head_vld),
		.head_cmd  (head_cmd),
		.pop       (pop),
		.out_char  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready)
	);

endmodule

[tb/dle_character_stuffing_framer_tb.sv]
// ---------------------------------------------------------------------------
// DLE/STX character-stuffing framer testbench
// Drives byte frames into the framer in both directions, predicts every
// output beat with a cycle-free model of the framing rules, and compares the
// output stream beat by beat. A short directed table comes first, then random
// frames with bursty input, a stalling receiver and one long output hold-off.
// ---------------------------------------------------------------------------
module dle_character_stuffing_framer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 330;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES  = 300;
	localparam int FIXED_W      = 13 * 8;
	localparam int PRINT_MAX    = 40;

	localparam string      DLE_STX = "dlestx";
	localparam logic [7:0] ASC_D   = "d";
	localparam logic [7:0] ASC_L   = "l";
	localparam logic [7:0] ASC_E   = "e";

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	// One row of the directed table. A nonzero fixed_text holds the output
	// text the row must produce, last character in the low byte.
	typedef struct packed {
		row_kind_t          kind;
		logic [7:0]         data;
		logic               last;
		logic [FIXED_W-1:0] fixed_text;
	} row_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} beat_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	// Framer state as the predictor sees it.
	logic [7:0] win [7];
	logic [3:0] frame_bytes_seen;
	logic [1:0] skip_left;
	logic       frame_open;
	logic       dir_destuff;

	beat_t      expected_beats [$];
	beat_t      step_beats [$];
	logic [7:0] raw_bytes [$];
	logic [7:0] frame_bytes [$];
	row_t       directed_rows [20];

	int  errors = 0;
	int  bytes_sent = 0;
	int  burst_left = 0;
	bit  gaps_on = 1'b1;
	bit  hold_req = 1'b0;

	dle_character_stuffing_framer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3ms;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_MAX) begin
			$display("%0t ERROR: %s", $realtime, msg);
		end
		errors++;
	endtask

	task automatic push_beat(input logic [7:0] ch, input logic last);
		step_beats.push_back(beat_t'{ch, last});
	endtask

	// Close the open frame, as the end of a frame or a direction write does.
	task automatic end_frame();
		frame_bytes_seen = '0;
		skip_left = '0;
		frame_open = 1'b0;
	endtask

	// Work out the output beats caused by one accepted input byte.
	task automatic predict_byte(input logic [7:0] ch, input logic last);
		int i;
		logic pair_match;
		logic [7:0] pick;
		step_beats.delete();
		for (i = 0; i < 6; i++) begin
			win[i] = win[i+1];
		end
		win[6] = ch;
		if (!dir_destuff) begin
			// Stuffing: opening flag, doubled "dle" two bytes behind, closing flag.
			if (!frame_open) begin
				for (i = 0; i < 6; i++) begin
					push_beat(DLE_STX[i], 1'b0);
				end
				frame_open = 1'b1;
				frame_bytes_seen = '0;
			end
			if (frame_bytes_seen >= 2) begin
				if (win[4] == ASC_D && win[5] == ASC_L && win[6] == ASC_E) begin
					push_beat(ASC_D, 1'b0);
					push_beat(ASC_L, 1'b0);
					push_beat(ASC_E, 1'b0);
				end
				push_beat(win[4], 1'b0);
			end
			if (last) begin
				if (frame_bytes_seen >= 1) begin
					push_beat(win[5], 1'b0);
				end
				push_beat(win[6], 1'b0);
				for (i = 0; i < 6; i++) begin
					push_beat(DLE_STX[i], i == 5);
				end
				end_frame();
			end else if (frame_bytes_seen < 12) begin
				frame_bytes_seen++;
			end
		end else begin
			// Destuffing: decide the byte six positions back.
			frame_open = 1'b1;
			if (frame_bytes_seen >= 12) begin
				pair_match = win[0] == ASC_D && win[1] == ASC_L && win[2] == ASC_E &&
					win[3] == ASC_D && win[4] == ASC_L && win[5] == ASC_E;
				if (last) begin
					if (skip_left > 0) begin
						pick = win[skip_left - 1];
					end else if (pair_match) begin
						pick = win[3];
					end else begin
						pick = win[0];
					end
					push_beat(pick, 1'b1);
				end else if (skip_left > 1) begin
					skip_left--;
				end else if (skip_left == 1) begin
					skip_left = '0;
					push_beat(win[0], 1'b0);
				end else if (pair_match) begin
					skip_left = 2'd3;
				end else begin
					push_beat(win[0], 1'b0);
				end
			end
			if (last) begin
				end_frame();
			end else if (frame_bytes_seen < 12) begin
				frame_bytes_seen++;
			end
		end
	endtask

	// Offer one byte in bursts with random gaps, then queue its expected beats.
	task automatic send_byte(input logic [7:0] ch, input logic last,
			input logic [FIXED_W-1:0] fixed_text);
		int gap;
		int i;
		logic [7:0] c;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gaps_on && gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		predict_byte(ch, last);
		if (fixed_text == '0) begin
			foreach (step_beats[k]) begin
				expected_beats.push_back(step_beats[k]);
			end
		end else begin
			for (i = FIXED_W / 8 - 1; i >= 0; i--) begin
				c = fixed_text[i*8 +: 8];
				if (c != 8'h00) begin
					expected_beats.push_back(beat_t'{c, (i == 0) ? last : 1'b0});
				end
			end
		end
		bytes_sent++;
	endtask

	// Let every expected beat arrive, then give the block time to settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_direction(input logic destuff);
		drain();
		cfg_wdata <= destuff;
		cfg_we <= 1'b1;
		@(posedge clk);
		dir_destuff = destuff;
		end_frame();
		cfg_we <= 1'b0;
		burst_left = 0;
	endtask

	// Raw frame content rich in "dle" runs, with some full-range bytes.
	task automatic add_payload(input int tokens);
		int t;
		for (t = 0; t < tokens; t++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					raw_bytes.push_back(ASC_D);
					raw_bytes.push_back(ASC_L);
					raw_bytes.push_back(ASC_E);
				end
				3: raw_bytes.push_back(8'($urandom_range(0, 255)));
				4: raw_bytes.push_back(DLE_STX[$urandom_range(0, 5)]);
				5: begin
					raw_bytes.push_back(ASC_D);
					raw_bytes.push_back(ASC_L);
				end
				default: raw_bytes.push_back(8'($urandom_range(8'h20, 8'h7e)));
			endcase
		end
	endtask

	task automatic add_flag();
		int i;
		for (i = 0; i < 6; i++) begin
			frame_bytes.push_back(DLE_STX[i]);
		end
	endtask

	// Build a well-formed stuffed frame around the raw content.
	task automatic build_framed();
		int i;
		frame_bytes.delete();
		add_flag();
		i = 0;
		while (i < raw_bytes.size()) begin
			if (i + 2 < raw_bytes.size() && raw_bytes[i] == ASC_D &&
					raw_bytes[i+1] == ASC_L && raw_bytes[i+2] == ASC_E) begin
				frame_bytes.push_back(ASC_D);
				frame_bytes.push_back(ASC_L);
				frame_bytes.push_back(ASC_E);
				frame_bytes.push_back(ASC_D);
				frame_bytes.push_back(ASC_L);
				frame_bytes.push_back(ASC_E);
				i += 3;
			end else begin
				frame_bytes.push_back(raw_bytes[i]);
				i++;
			end
		end
		add_flag();
	endtask

	task automatic send_frame(input logic closed);
		int i;
		for (i = 0; i < frame_bytes.size(); i++) begin
			send_byte(frame_bytes[i], closed && i == frame_bytes.size() - 1, '0);
		end
	endtask

	// Receiver: changing ready patterns, plus one long hold-off on request.
	initial begin
		int mode;
		int mode_left;
		int hold_left;
		int tick;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= (tick % 3 == 0);
				endcase
			end
		end
	end

	// Compare each output beat with the oldest expected one.
	always @(posedge clk) begin
		beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat char 0x%02h last %0b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = expected_beats.pop_front();
				if (m_axis_tdata !== want.ch) begin
					report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
						m_axis_tdata, want.ch));
				end
				if (m_axis_tlast !== want.last) begin
					report_mismatch($sformatf("last %0b, expected %0b on char 0x%02h",
						m_axis_tlast, want.last, want.ch));
				end
			end
		end
	end

	// Stimulus: directed table, then random phases in both directions.
	initial begin
		int phase;
		int frames;
		int f;
		int n;
		int target;
		int wait_left;
		logic closed;
		for (n = 0; n < 7; n++) begin
			win[n] = 8'h00;
		end
		end_frame();
		dir_destuff = 1'b0;

		directed_rows = '{
			// Single-byte stuff frame gives the longest output burst.
			'{ROW_BYTE, "A", 1'b1, "dlestxAdlestx"},
			// A frame of just "dle" is doubled; its match stays inside the frame.
			'{ROW_BYTE, "d", 1'b0, '0},
			'{ROW_BYTE, "l", 1'b0, '0},
			'{ROW_BYTE, "e", 1'b1, '0},
			// Byte extremes.
			'{ROW_BYTE, 8'h00, 1'b0, '0},
			'{ROW_BYTE, 8'hff, 1'b1, '0},
			'{ROW_CFG,  8'h01, 1'b0, '0},
			// Shortest destuff frame that yields data.
			'{ROW_BYTE, "d", 1'b0, '0},
			'{ROW_BYTE, "l", 1'b0, '0},
			'{ROW_BYTE, "e", 1'b0, '0},
			'{ROW_BYTE, "s", 1'b0, '0},
			'{ROW_BYTE, "t", 1'b0, '0},
			'{ROW_BYTE, "x", 1'b0, '0},
			'{ROW_BYTE, "K", 1'b0, '0},
			'{ROW_BYTE, "d", 1'b0, '0},
			'{ROW_BYTE, "l", 1'b0, '0},
			'{ROW_BYTE, "e", 1'b0, '0},
			'{ROW_BYTE, "s", 1'b0, '0},
			'{ROW_BYTE, "t", 1'b0, '0},
			'{ROW_BYTE, "x", 1'b1, FIXED_W'("K")}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_CFG) begin
				set_direction(directed_rows[r].data[0]);
			end else begin
				send_byte(directed_rows[r].data, directed_rows[r].last,
					directed_rows[r].fixed_text);
			end
		end

		target = bytes_sent + RANDOM_ITEMS;
		phase = 0;
		while (bytes_sent < target) begin
			if (phase < 2) begin
				set_direction(phase == 1);
			end else begin
				set_direction($urandom_range(0, 1));
			end
			// First phase: no input gaps, a long output hold-off and enough
			// frames to fill the command queue.
			gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
			if (phase == 0) begin
				hold_req = 1'b1;
			end
			frames = (phase == 0) ? 8 : $urandom_range(2, 6);
			for (f = 0; f < frames; f++) begin
				closed = (f != frames - 1) || ($urandom_range(0, 3) != 0);
				raw_bytes.delete();
				if (!dir_destuff) begin
					add_payload($urandom_range(1, 6));
					if ($urandom_range(0, 4) == 0) begin
						while (raw_bytes.size() > $urandom_range(1, 2)) begin
							void'(raw_bytes.pop_back());
						end
					end
					frame_bytes = raw_bytes;
				end else begin
					case ($urandom_range(0, 9))
						7: begin
							// Noise taken as it comes.
							add_payload($urandom_range(1, 8));
							frame_bytes = raw_bytes;
						end
						8: begin
							// Well-formed frame with one byte corrupted.
							add_payload($urandom_range(0, 5));
							build_framed();
							n = $urandom_range(0, frame_bytes.size() - 1);
							frame_bytes[n] = 8'($urandom_range(0, 255));
						end
						9: begin
							// Well-formed frame with one byte missing.
							add_payload($urandom_range(0, 5));
							build_framed();
							frame_bytes.delete($urandom_range(0, frame_bytes.size() - 1));
						end
						default: begin
							add_payload($urandom_range(0, 5));
							build_framed();
						end
					endcase
				end
				send_frame(closed);
			end
			phase++;
		end

		// Wait for the tail of the output, with a bound.
		s_axis_tvalid <= 1'b0;
		wait_left = 50000;
		while (expected_beats.size() != 0 && wait_left > 0) begin
			@(posedge clk);
			wait_left--;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_beats.size() != 0) begin
			report_mismatch($sformatf("%0d expected beats never arrived",
				expected_beats.size()));
		end
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
